>>> rtl/kdj_pkg.sv
// Shared types and constants for the KDJ stochastic oscillator core.
// No dependencies; imported by kdj_stochastic_oscillator_core.
`default_nettype none

package kdj_pkg;

  // Default build-time sizes
  localparam int DefWindowMax = 16;
  localparam int DefFracBits  = 16;

  // Fixed field widths
  localparam int PriceW = 32;
  localparam int CfgW   = 5;

  // Window length after reset
  localparam logic [CfgW-1:0] WlenReset = CfgW'(9);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RSV,
    ST_MUL,
    ST_DIV,
    ST_K3M,
    ST_K3F,
    ST_D3M,
    ST_D3F,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

>>> rtl/kdj_stochastic_oscillator_core.sv
// KDJ stochastic oscillator: high/low history memories, window scan,
// serial RSV divider and K/D smoothing. Depends on kdj_pkg.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ----------------------------------------
// in        sink       in_valid_i / in_stall_o   day_high_i day_low_i day_close_i restart_i
// out       source     out_valid_o / out_stall_i k_value_o d_value_o j_value_o
//                                                ready_res_o flat_window_o
// cfg       sink       cfg_we_i                  cfg_wdata_i (window_length)
//
// One item at a time. An item that does not fill the window, or that seeds it,
// goes straight to the output register. A full-window item scans its n newest
// days (n is the clamped window length) through the single read port of the
// history memories, then goes through the multiply, the bit-serial RSV divider
// and the two divide-by-3 steps. A flat or saturated window skips the divider.
// The next item is taken once the result sits in the output register; a stalled
// result holds the block only at the final hand-off.
// Reset clears control state, the window length to 9 and K/D to 50; the history
// memories are not cleared, only entries written since the last restart are read.

module kdj_stochastic_oscillator_core #(
  parameter int WINDOW_MAX = kdj_pkg::DefWindowMax,
  parameter int FRAC_BITS  = kdj_pkg::DefFracBits
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [kdj_pkg::CfgW-1:0]    cfg_wdata_i,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [kdj_pkg::PriceW-1:0]  day_high_i,
  input  wire logic [kdj_pkg::PriceW-1:0]  day_low_i,
  input  wire logic [kdj_pkg::PriceW-1:0]  day_close_i,
  input  wire logic                        restart_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [FRAC_BITS+6:0]             k_value_o,
  output logic [FRAC_BITS+6:0]             d_value_o,
  output logic signed [FRAC_BITS+8:0]      j_value_o,
  output logic                             ready_res_o,
  output logic                             flat_window_o
);

  import kdj_pkg::*;

  // Widths
  localparam int KW  = FRAC_BITS + 7;           // K/D line and RSV quotient
  localparam int XW  = KW + 2;                  // 2*line + term, below 3*2^KW
  localparam int JW  = KW + 2;                  // signed J
  localparam int PW  = PriceW + KW;             // RSV numerator
  localparam int AW  = $clog2(WINDOW_MAX);      // history address
  localparam int CW  = $clog2(WINDOW_MAX + 1);  // day counter, holds WINDOW_MAX
  localparam int LW  = (CW > CfgW) ? CW : CfgW; // window length compare width
  localparam int DCW = $clog2(KW + 1);          // divider step counter

  localparam logic [KW-1:0] Fix50  = KW'(50) << FRAC_BITS;
  localparam logic [KW-1:0] Fix100 = KW'(100) << FRAC_BITS;
  localparam logic [XW-1:0] Recip3 = XW'(((XW + 1)'(1) << XW) / 3);
  localparam logic [AW-1:0] LastSlot = AW'(WINDOW_MAX - 1);

  // History memories
  logic [PriceW-1:0] high_mem [WINDOW_MAX];
  logic [PriceW-1:0] low_mem  [WINDOW_MAX];

  // Control state
  state_e            state_q, state_d;
  logic [CfgW-1:0]   wlen_q;
  logic [AW-1:0]     slot_q;
  logic [CW-1:0]     days_q;
  logic [KW-1:0]     k_q, d_q;
  logic [CW-1:0]     issue_left_q;
  logic              rd_vld_q;
  logic [DCW-1:0]    div_cnt_q;
  logic              res_ready_q;
  logic              flat_q;
  logic              out_valid_q;

  // Datapath registers
  logic [AW-1:0]     rd_addr_q;
  logic [PriceW-1:0] hi_rd_q, lo_rd_q;
  logic [PriceW-1:0] cl_q;
  logic [PriceW-1:0] whigh_q, wlow_q;
  logic [PriceW-1:0] diff_q, dvs_q;
  logic [PriceW-1:0] rem_q;
  logic [KW-1:0]     num_q;
  logic [XW-1:0]     x_q;
  logic [XW-1:0]     q0_q;
  logic [KW-1:0]     k_out_q, d_out_q;
  logic [JW-1:0]     j_out_q;
  logic              ready_out_q, flat_out_q;

  // Control strobes
  logic acc, rd_en, out_load;

  // Accept-time decode
  logic [LW-1:0]   wl_ext, n_eff;
  logic [CW-1:0]   n_c;
  logic [AW-1:0]   base_slot, slot_next;
  logic [CW-1:0]   base_days, days_new;
  logic            acc_wait, acc_seed;

  // Scan, RSV, divider, divide-by-3
  logic [AW-1:0]     addr_prev;
  logic              rsv_flat, cl_lo, cl_hi;
  logic [PW-1:0]     prod;
  logic [PriceW:0]   r2, r_sub;
  logic              ge;
  logic [PriceW-1:0] rem_next;
  logic [KW-1:0]     num_next;
  logic [2*XW-1:0]   m3;
  logic [XW-1:0]     r3, q3_full;
  logic [KW-1:0]     q3;
  logic [JW-1:0]     j_calc;

  // Clamp window length: 0 acts as 1, above WINDOW_MAX acts as WINDOW_MAX
  always_comb begin
    wl_ext = LW'(wlen_q);
    if (wl_ext == '0) begin
      n_eff = LW'(1);
    end else if (wl_ext > LW'(WINDOW_MAX)) begin
      n_eff = LW'(WINDOW_MAX);
    end else begin
      n_eff = wl_ext;
    end
    n_c = n_eff[CW-1:0];
  end

  // Restart clears history before the day is taken
  always_comb begin
    base_slot = restart_i ? '0 : slot_q;
    base_days = restart_i ? '0 : days_q;
    slot_next = (base_slot == LastSlot) ? '0 : base_slot + AW'(1);
    days_new  = (base_days < CW'(WINDOW_MAX)) ? base_days + CW'(1) : base_days;
    acc_wait  = days_new < n_c;
    acc_seed  = !acc_wait && (base_days < n_c);
  end

  assign addr_prev = (rd_addr_q == '0) ? LastSlot : rd_addr_q - AW'(1);

  // RSV decisions
  assign rsv_flat = whigh_q <= wlow_q;
  assign cl_lo    = cl_q <= wlow_q;
  assign cl_hi    = cl_q >= whigh_q;
  assign prod     = PW'(diff_q) * PW'(Fix100);

  // Restoring divider step, quotient shifts into num_q
  always_comb begin
    r2       = {rem_q, num_q[KW-1]};
    r_sub    = r2 - {1'b0, dvs_q};
    ge       = r2 >= {1'b0, dvs_q};
    rem_next = ge ? r_sub[PriceW-1:0] : r2[PriceW-1:0];
    num_next = {num_q[KW-2:0], ge};
  end

  // Divide by 3: reciprocal estimate then one correction
  always_comb begin
    m3      = {{XW{1'b0}}, x_q} * {{XW{1'b0}}, Recip3};
    r3      = x_q - (q0_q + {q0_q[XW-2:0], 1'b0});
    q3_full = (r3 >= XW'(3)) ? q0_q + XW'(1) : q0_q;
    q3      = q3_full[KW-1:0];
  end

  // J = 3K - 2D
  assign j_calc = ({2'b00, k_q} + {1'b0, k_q, 1'b0}) - {1'b0, d_q, 1'b0};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          state_d = (acc_wait || acc_seed) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_left_q == '0 && rd_vld_q) begin
          state_d = ST_RSV;
        end
      end
      ST_RSV: begin
        if (rsv_flat) begin
          state_d = ST_D3M;
        end else if (cl_lo || cl_hi) begin
          state_d = ST_K3M;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_cnt_q == DCW'(1)) begin
          state_d = ST_K3M;
        end
      end
      ST_K3M:  state_d = ST_K3F;
      ST_K3F:  state_d = ST_D3M;
      ST_D3M:  state_d = ST_D3F;
      ST_D3F:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Strobes
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_SCAN: rd_en      = issue_left_q != '0;
      ST_OUT:  out_load   = !out_valid_q || !out_stall_i;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign acc = in_valid_i && !in_stall_o;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wlen_q       <= WlenReset;
      slot_q       <= '0;
      days_q       <= '0;
      k_q          <= Fix50;
      d_q          <= Fix50;
      issue_left_q <= '0;
      rd_vld_q     <= 1'b0;
      div_cnt_q    <= '0;
      res_ready_q  <= 1'b0;
      flat_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
      end
      if (acc) begin
        slot_q       <= slot_next;
        days_q       <= days_new;
        res_ready_q  <= !acc_wait;
        flat_q       <= 1'b0;
        issue_left_q <= (acc_wait || acc_seed) ? '0 : n_c;
        if (restart_i || acc_seed) begin
          k_q <= Fix50;
          d_q <= Fix50;
        end
      end
      if (rd_en) begin
        issue_left_q <= issue_left_q - CW'(1);
      end
      if (state_q == ST_RSV && rsv_flat) begin
        flat_q <= 1'b1;
      end
      if (state_q == ST_MUL) begin
        div_cnt_q <= DCW'(KW);
      end else if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q - DCW'(1);
      end
      if (state_q == ST_K3F) begin
        k_q <= q3;
      end
      if (state_q == ST_D3F) begin
        d_q <= q3;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // History memories: write on accept, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (acc) begin
      high_mem[base_slot] <= day_high_i;
      low_mem[base_slot]  <= day_low_i;
    end
    if (rd_en) begin
      hi_rd_q <= high_mem[rd_addr_q];
      lo_rd_q <= low_mem[rd_addr_q];
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cl_q      <= day_close_i;
      rd_addr_q <= base_slot;
      whigh_q   <= '0;
      wlow_q    <= '1;
    end
    if (rd_en) begin
      rd_addr_q <= addr_prev;
    end
    // fold in the newest-first window entries
    if (rd_vld_q) begin
      if (hi_rd_q > whigh_q) begin
        whigh_q <= hi_rd_q;
      end
      if (lo_rd_q < wlow_q) begin
        wlow_q <= lo_rd_q;
      end
    end
    case (state_q)
      ST_RSV: begin
        diff_q <= cl_q - wlow_q;
        dvs_q  <= whigh_q - wlow_q;
        if (rsv_flat) begin
          x_q <= {1'b0, d_q, 1'b0} + XW'(k_q);
        end else if (cl_lo) begin
          x_q <= {1'b0, k_q, 1'b0};
        end else begin
          x_q <= {1'b0, k_q, 1'b0} + XW'(Fix100);
        end
      end
      ST_MUL: begin
        rem_q <= prod[PW-1:KW];
        num_q <= prod[KW-1:0];
      end
      ST_DIV: begin
        rem_q <= rem_next;
        num_q <= num_next;
        x_q   <= {1'b0, k_q, 1'b0} + XW'(num_next);
      end
      ST_K3M, ST_D3M: begin
        q0_q <= m3[2*XW-1:XW];
      end
      ST_K3F: begin
        x_q <= {1'b0, d_q, 1'b0} + XW'(q3);
      end
      default: begin
        q0_q <= q0_q;
      end
    endcase
    if (out_load) begin
      k_out_q     <= res_ready_q ? k_q : '0;
      d_out_q     <= res_ready_q ? d_q : '0;
      j_out_q     <= res_ready_q ? j_calc : '0;
      ready_out_q <= res_ready_q;
      flat_out_q  <= flat_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign k_value_o     = k_out_q;
  assign d_value_o     = d_out_q;
  assign j_value_o     = $signed(j_out_q);
  assign ready_res_o   = ready_out_q;
  assign flat_window_o = flat_out_q;

endmodule

`default_nettype wire

>>> dv/kdj_stochastic_oscillator_core_tb.sv
// Self-checking testbench for kdj_stochastic_oscillator_core: a clocked driver and
// monitor around the core, with a bit-exact KDJ predictor kept inside the bench.
// Depends on kdj_pkg and the core RTL only.

module kdj_stochastic_oscillator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kdj_pkg::*;

  localparam int WindowMax = DefWindowMax;
  localparam int FracBits  = DefFracBits;
  localparam int KdW       = FracBits + 7;
  localparam int JW        = FracBits + 9;

  localparam longint unsigned Fix50  = 64'd50 << FracBits;
  localparam longint unsigned Fix100 = 64'd100 << FracBits;

  localparam int CycleLimit = 400_000;
  localparam int HoldAt     = 300;   // items taken before the long receiver hold-off
  localparam int HoldCycles = 400;
  localparam int TailCycles = 64;    // longer than one full-window item
  localparam int RandPhases = 8;
  localparam int PhaseDays  = 142;

  typedef struct packed {
    logic [PriceW-1:0] high;
    logic [PriceW-1:0] low;
    logic [PriceW-1:0] close;
    logic              restart;
  } kdj_day_t;

  typedef struct packed {
    logic [KdW-1:0] k;
    logic [KdW-1:0] d;
    logic [JW-1:0]  j;
    logic           ready;
    logic           flat;
  } kdj_line_t;

  // DUT connections; every input starts at a known value
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CfgW-1:0]          cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [PriceW-1:0]        day_high_i  = '0;
  logic [PriceW-1:0]        day_low_i   = '0;
  logic [PriceW-1:0]        day_close_i = '0;
  logic                     restart_i   = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [KdW-1:0]           k_value_o;
  logic [KdW-1:0]           d_value_o;
  logic signed [JW-1:0]     j_value_o;
  logic                     ready_res_o;
  logic                     flat_window_o;

  kdj_stochastic_oscillator_core #(
    .WINDOW_MAX(WindowMax),
    .FRAC_BITS (FracBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .day_high_i   (day_high_i),
    .day_low_i    (day_low_i),
    .day_close_i  (day_close_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .k_value_o    (k_value_o),
    .d_value_o    (d_value_o),
    .j_value_o    (j_value_o),
    .ready_res_o  (ready_res_o),
    .flat_window_o(flat_window_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // KDJ predictor: its own history ring, day count, K/D lines and window length
  // ---------------------------------------------------------------------------
  logic [PriceW-1:0] seen_high [WindowMax];
  logic [PriceW-1:0] seen_low  [WindowMax];
  int unsigned       ring_slot  = 0;
  int unsigned       days_held  = 0;
  int unsigned       window_len = WlenReset;
  longint unsigned   k_track    = Fix50;
  longint unsigned   d_track    = Fix50;

  int unsigned seed_days = 0;
  int unsigned flat_days = 0;

  // Advance the predictor by one day and return the line the core must produce.
  function automatic kdj_line_t advance_kdj(kdj_day_t day);
    kdj_line_t         line;
    int unsigned       n, prev_held, idx;
    logic [PriceW-1:0] win_lo, win_hi;
    longint unsigned   rsv;
    longint            j_full;
    line = '0;
    // Out-of-range lengths: zero acts as one, anything above the ring size as the ring size
    n = (window_len < 1) ? 1 : (window_len > WindowMax) ? WindowMax : window_len;
    if (day.restart) begin
      ring_slot = 0;
      days_held = 0;
      k_track   = Fix50;
      d_track   = Fix50;
    end
    seen_high[ring_slot] = day.high;
    seen_low[ring_slot]  = day.low;
    ring_slot = (ring_slot + 1) % WindowMax;
    prev_held = days_held;
    if (days_held < WindowMax) days_held++;
    // Window not full yet: all zeros, lines untouched
    if (days_held < n) return line;
    line.ready = 1'b1;
    // Day that fills the window: seed both lines, J reported as 50 too
    if (prev_held < n) begin
      k_track = Fix50;
      d_track = Fix50;
      line.k  = KdW'(Fix50);
      line.d  = KdW'(Fix50);
      line.j  = JW'(Fix50);
      seed_days++;
      return line;
    end
    win_lo = '1;
    win_hi = '0;
    for (int unsigned i = 0; i < n; i++) begin
      idx = (ring_slot + 2 * WindowMax - 1 - i) % WindowMax;
      if (seen_low[idx] < win_lo) win_lo = seen_low[idx];
      if (seen_high[idx] > win_hi) win_hi = seen_high[idx];
    end
    // Flat or inverted window holds K
    if (win_hi <= win_lo) begin
      line.flat = 1'b1;
      flat_days++;
    end else begin
      if (day.close <= win_lo) rsv = 0;
      else if (day.close >= win_hi) rsv = Fix100;
      else rsv = (longint'(day.close - win_lo) * Fix100) / longint'(win_hi - win_lo);
      k_track = (2 * k_track + rsv) / 3;
    end
    d_track = (2 * d_track + k_track) / 3;
    j_full  = 3 * longint'(k_track) - 2 * longint'(d_track);
    line.k  = k_track[KdW-1:0];
    line.d  = d_track[KdW-1:0];
    line.j  = j_full[JW-1:0];
    return line;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  kdj_day_t    day_queue [$];   // days waiting to be offered
  kdj_line_t   kdj_due   [$];   // predicted lines, oldest first
  int unsigned days_taken    = 0;
  int unsigned lines_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned window_writes = 0;
  int unsigned send_odds     = 0;   // 1-in-N chance of a sender gap after each item
  int unsigned recv_odds     = 0;   // 1-in-N chance per cycle of a receiver stall burst
  int unsigned cycle_count   = 0;
  int unsigned hold_left     = 0;
  logic        hold_used     = 1'b0;

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH at line %0d, %s: got %0h, expected %0h",
               lines_checked, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued days, hold a stalled day steady, idle in short bursts
  // ---------------------------------------------------------------------------
  kdj_day_t    offered_day = '0;
  int unsigned send_gap    = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      // Predict at the edge where the core takes the day
      if (in_valid_i && !in_stall_o) begin
        kdj_due.push_back(advance_kdj(offered_day));
        days_taken <= days_taken + 1;
        if (send_odds != 0 && $urandom_range(1, send_odds) == 1)
          send_gap = $urandom_range(1, 3);
      end
      // Hold the payload while stalled; otherwise pick the next step
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (day_queue.size() != 0) begin
          offered_day = day_queue.pop_front();
          in_valid_i  <= 1'b1;
          day_high_i  <= offered_day.high;
          day_low_i   <= offered_day.low;
          day_close_i <= offered_day.close;
          restart_i   <= offered_day.restart;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off: once, early in the random part, stop draining results
  // for a long stretch while the driver keeps offering so the core backs up
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!hold_used && days_taken >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each taken result against the oldest prediction, then drive stall
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    kdj_line_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (kdj_due.size() == 0) begin
          report_mismatch("result with nothing pending", k_value_o, 0);
        end else begin
          want = kdj_due.pop_front();
          if (k_value_o !== want.k) report_mismatch("k_value", k_value_o, want.k);
          if (d_value_o !== want.d) report_mismatch("d_value", d_value_o, want.d);
          if (j_value_o !== want.j) report_mismatch("j_value", j_value_o, want.j);
          if (ready_res_o !== want.ready)
            report_mismatch("ready_res", ready_res_o, want.ready);
          if (flat_window_o !== want.flat)
            report_mismatch("flat_window", flat_window_o, want.flat);
        end
        lines_checked++;
      end
      if (stall_left != 0) stall_left--;
      else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1)
        stall_left = $urandom_range(1, 3);
      out_stall_i <= (stall_left != 0) || (hold_left != 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, kdj_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [PriceW-1:0] to_price(longint v);
    if (v < 0) return '0;
    if (v > longint'(64'hFFFF_FFFF)) return '1;
    return v[PriceW-1:0];
  endfunction

  task automatic add_day(logic [PriceW-1:0] h, logic [PriceW-1:0] l,
                         logic [PriceW-1:0] c, logic r);
    kdj_day_t day;
    day.high    = h;
    day.low     = l;
    day.close   = c;
    day.restart = r;
    day_queue.push_back(day);
  endtask

  // Wait until every day is taken and every line checked; sample on the falling edge
  task automatic wait_drained();
    do @(negedge clk_i);
    while (day_queue.size() != 0 || kdj_due.size() != 0 || in_valid_i);
  endtask

  // Write the window length while the core is idle, then return on a falling edge
  task automatic set_window(int unsigned len);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CfgW'(len);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    window_len  = len % (1 << CfgW);
    window_writes++;
    @(negedge clk_i);
  endtask

  // Queue a random price series: mostly well-formed bars drifting around a base,
  // with flat runs, inverted bars, closes outside the range and raw noise mixed in.
  task automatic queue_series(int unsigned count, int unsigned span_bits);
    longint   span_mask, base, drift, hi, lo, cl;
    int       pick;
    int       flat_run;
    kdj_day_t day;
    span_mask = (longint'(1) << span_bits) - 1;
    base      = longint'($urandom);
    flat_run  = 0;
    for (int unsigned i = 0; i < count; i++) begin
      pick        = $urandom_range(0, 29);
      day.restart = (i == 0) ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 39) == 0);
      drift       = (longint'($urandom) & span_mask) / 8;
      base        = $urandom_range(0, 1) ? base + drift : base - drift;
      base        = longint'(to_price(base));
      if (flat_run == 0 && pick == 29) flat_run = $urandom_range(2, 20);
      if (flat_run != 0) begin
        // constant bars so a whole window goes flat
        flat_run--;
        hi = base;
        lo = base;
        cl = (pick < 10) ? longint'($urandom) : base;
      end else if (pick == 0) begin
        hi = longint'($urandom);
        lo = longint'($urandom);
        cl = longint'($urandom);
      end else if (pick == 1) begin
        // low above high
        hi = base;
        lo = base + 1 + (longint'($urandom) & span_mask);
        cl = base;
      end else begin
        lo = base - (longint'($urandom) & span_mask);
        hi = base + (longint'($urandom) & span_mask);
        case (pick)
          2:       cl = lo - 1 - (longint'($urandom) & span_mask);
          3:       cl = hi + 1 + (longint'($urandom) & span_mask);
          4:       cl = hi;
          5:       cl = lo;
          default: cl = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
        endcase
      end
      day.high  = to_price(hi);
      day.low   = to_price(lo);
      day.close = to_price(cl);
      day_queue.push_back(day);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  int unsigned phase_window [RandPhases];
  int unsigned phase_send   [RandPhases] = '{4, 0, 6, 3, 4, 0, 8, 0};
  int unsigned phase_recv   [RandPhases] = '{4, 5, 0, 3, 6, 0, 4, 0};

  initial begin
    // Extremes of the register, out-of-range codes and a couple of random lengths
    phase_window = '{16, 2, 17, $urandom_range(1, 16), 1, 31, 0, $urandom_range(1, 16)};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: default window of 9, from a restart through the seed day and beyond
    add_day('1, '0, '0, 1'b1);
    for (int i = 0; i < 7; i++) add_day(32'd1000 + i, 32'd900 - i, 32'd950, 1'b0);
    add_day('1, '1, '1, 1'b0);                // seed day, all-ones prices
    add_day(32'd2000, 32'd1500, '1, 1'b0);    // close at the window high
    add_day(32'd2000, 32'd1500, '0, 1'b0);    // close below the window low
    wait_drained();

    // Window of one: every bar is its own window
    set_window(1);
    add_day(32'd5, 32'd5, 32'd5, 1'b0);       // flat
    add_day(32'd3, 32'd7, 32'd5, 1'b0);       // inverted
    add_day('1, '0, 32'h7FFF_FFFF, 1'b0);     // full price range
    add_day(32'd100, 32'd0, 32'd100, 1'b0);   // close equals high
    add_day(32'd100, 32'd10, 32'd10, 1'b0);   // close equals low
    wait_drained();

    // Zero acts as one; restart right away seeds on its own bar
    set_window(0);
    add_day(32'd200, 32'd100, 32'd150, 1'b1);
    add_day(32'd300, 32'd200, 32'd250, 1'b0);
    wait_drained();

    // Oversized code acts as the full ring; too few days held, so not ready
    set_window(31);
    for (int i = 0; i < 4; i++) add_day(32'd400 + i, 32'd300, 32'd350, 1'b0);
    wait_drained();

    // Random phases, each with its own window length, span and idling mix
    for (int p = 0; p < RandPhases; p++) begin
      set_window(phase_window[p]);
      send_odds = phase_send[p];
      recv_odds = phase_recv[p];
      queue_series(PhaseDays, $urandom_range(0, 3) == 0 ? 32 : $urandom_range(1, 12));
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);

    $display("Checked %0d result lines from %0d days over %0d window length writes",
             lines_checked, days_taken, window_writes);
    $display("Seed days %0d, flat or inverted windows %0d, long receiver hold-off %0s",
             seed_days, flat_days, hold_used ? "done" : "missed");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
